@@ hdl/epf_pkg.sv @@
// Shared types and constants for the escaped packet framer.
// Holds the register map, controller/datapath command and status structs,
// and the controller state type. No dependencies.
`default_nettype none

package epf_pkg;

    // Buffer half capacity and payload limit of this build
    localparam int unsigned BUFFER_BYTES      = 16384;
    localparam int unsigned MAX_PAYLOAD_BYTES = 8;

    // Usable size can never exceed what the 15-bit size register holds
    localparam logic [14:0] BUF_LIMIT =
        15'((BUFFER_BYTES > 32767) ? 32767 : BUFFER_BYTES);
    localparam logic [3:0]  PAYLOAD_MAX =
        4'((MAX_PAYLOAD_BYTES < 8) ? MAX_PAYLOAD_BYTES : 8);

    // Header bytes: timestamp (4) plus frame id (2)
    localparam logic [3:0]  HDR_BYTES = 4'd6;

    // Stream widths
    localparam int unsigned S_TDATA_W = 120;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned M_TUSER_W = 2;

    // Register map (word index into APB space)
    typedef enum logic [1:0] {
        REG_BUFFER_SIZE   = 2'd0,
        REG_START_MARKER  = 2'd1,
        REG_ESCAPE_MARKER = 2'd2,
        REG_ESCAPE_MASK   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [14:0] buffer_size;
        logic [7:0]  start_marker;
        logic [7:0]  escape_marker;
        logic [7:0]  escape_mask;
    } cfg_t;

    // What the datapath places in the output register this cycle
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_START,
        EMIT_ESC,
        EMIT_BYTE,
        EMIT_XOR,
        EMIT_SWAP,
        EMIT_REJECT
    } emit_t;

    typedef struct packed {
        logic  load;
        emit_t emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_swap;
        logic reject;
        logic cur_esc;
        logic last_byte;
        logic out_free;
    } ctrl_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BYTE,
        ST_XOR
    } state_t;

endpackage

`default_nettype wire

@@ hdl/epf_regs.sv @@
// APB configuration registers of the escaped packet framer.
// Depends on epf_pkg for the register map and cfg_t.
`default_nettype none

module epf_regs import epf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_BUFFER_SIZE:   cfg_next.buffer_size   = pwdata[14:0];
                REG_START_MARKER:  cfg_next.start_marker  = pwdata[7:0];
                REG_ESCAPE_MARKER: cfg_next.escape_marker = pwdata[7:0];
                REG_ESCAPE_MASK:   cfg_next.escape_mask   = pwdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.buffer_size   <= 15'd16384;
            cfg_reg.start_marker  <= 8'd126;
            cfg_reg.escape_marker <= 8'd125;
            cfg_reg.escape_mask   <= 8'd32;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        unique case (idx)
            REG_BUFFER_SIZE:   prdata = {17'd0, cfg_reg.buffer_size};
            REG_START_MARKER:  prdata = {24'd0, cfg_reg.start_marker};
            REG_ESCAPE_MARKER: prdata = {24'd0, cfg_reg.escape_marker};
            REG_ESCAPE_MASK:   prdata = {24'd0, cfg_reg.escape_mask};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/epf_ctrl.sv @@
// Controller state machine of the escaped packet framer.
// Sequences check, start byte and stuffed bytes; depends on epf_pkg.
`default_nettype none

module epf_ctrl import epf_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.out_free) begin
                    if (status.is_swap || status.reject) state_next = ST_IDLE;
                    else                                 state_next = ST_BYTE;
                end
            end
            ST_BYTE: begin
                if (status.out_free) begin
                    if (status.cur_esc)        state_next = ST_XOR;
                    else if (status.last_byte) state_next = ST_IDLE;
                    else                       state_next = ST_BYTE;
                end
            end
            ST_XOR: begin
                if (status.out_free) begin
                    state_next = status.last_byte ? ST_IDLE : ST_BYTE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        in_ready = 1'b0;
        cmd.load = 1'b0;
        cmd.emit = EMIT_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK: begin
                if (status.out_free) begin
                    priority if (status.is_swap) cmd.emit = EMIT_SWAP;
                    else if (status.reject)     cmd.emit = EMIT_REJECT;
                    else                        cmd.emit = EMIT_START;
                end
            end
            ST_BYTE: begin
                if (status.out_free) cmd.emit = status.cur_esc ? EMIT_ESC : EMIT_BYTE;
            end
            ST_XOR: begin
                if (status.out_free) cmd.emit = EMIT_XOR;
            end
            default: cmd.emit = EMIT_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/epf_datapath.sv @@
// Datapath of the escaped packet framer: item latch, byte shifter,
// fill level, write side and output register. Depends on epf_pkg.
`default_nettype none

module epf_datapath import epf_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  cfg_t                        cfg,
    input  wire logic                   in_req_type,
    input  wire logic [31:0]            in_timestamp,
    input  wire logic [15:0]            in_frame_id,
    input  wire logic [63:0]            in_payload,
    input  wire logic [3:0]             in_payload_bytes,
    input  ctrl_cmd_t                   cmd,
    output ctrl_status_t                status,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        out_write_enable,
    output logic                        out_buffer_side,
    output logic [13:0]                 out_write_offset,
    output logic [7:0]                  out_byte,
    output logic                        out_status,
    output logic                        out_last
);

    // Item latch
    logic         swap_reg;
    logic [111:0] seq_reg;
    logic [111:0] seq_next;
    logic [3:0]   cnt_reg;
    logic [3:0]   cnt_next;

    // Framer state
    logic [14:0]  fill_reg;
    logic [14:0]  fill_next;
    logic         side_reg;
    logic         side_next;

    // Output register
    logic         ovalid_reg;
    logic         ovalid_next;
    logic         owe_reg,   owe_next;
    logic         oside_reg, oside_next;
    logic [13:0]  ooff_reg,  ooff_next;
    logic [7:0]   obyte_reg, obyte_next;
    logic         ost_reg,   ost_next;
    logic         olast_reg, olast_next;

    logic [3:0]   n_clamp;
    logic [5:0]   pl_shift;
    logic [63:0]  pl_aligned;
    logic [7:0]   cur_byte;
    logic [14:0]  size_eff;
    logic [4:0]   need;
    logic [15:0]  fill_end;
    logic         advance;

    // Align payload so byte n-1 sits at the top
    assign n_clamp    = (in_payload_bytes > PAYLOAD_MAX) ? PAYLOAD_MAX : in_payload_bytes;
    assign pl_shift   = {3'(4'd8 - n_clamp), 3'd0};
    assign pl_aligned = in_payload << pl_shift;

    assign cur_byte = seq_reg[111:104];

    // Worst-case space check: (7+n)*2 against size minus fill
    assign size_eff = (cfg.buffer_size < BUF_LIMIT) ? cfg.buffer_size : BUF_LIMIT;
    assign need     = {cnt_reg + 4'd1, 1'b0};
    assign fill_end = {1'b0, fill_reg} + 16'(need);

    assign status.is_swap   = swap_reg;
    assign status.reject    = fill_end > {1'b0, size_eff};
    assign status.cur_esc   = (cur_byte == cfg.start_marker) ||
                              (cur_byte == cfg.escape_marker);
    assign status.last_byte = (cnt_reg == 4'd1);
    assign status.out_free  = !ovalid_reg || out_ready;

    // Item latch and byte shifter
    assign advance = (cmd.emit == EMIT_BYTE) || (cmd.emit == EMIT_XOR);

    always_comb begin
        seq_next = seq_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            seq_next = {in_timestamp, in_frame_id, pl_aligned};
            cnt_next = HDR_BYTES + n_clamp;
        end else if (advance) begin
            seq_next = {seq_reg[103:0], 8'd0};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg <= seq_next;
        cnt_reg <= cnt_next;
        if (cmd.load) swap_reg <= in_req_type;
    end

    // Result formation and state update
    always_comb begin
        fill_next   = fill_reg;
        side_next   = side_reg;
        owe_next    = 1'b1;
        oside_next  = side_reg;
        ooff_next   = fill_reg[13:0];
        obyte_next  = 8'd0;
        ost_next    = 1'b0;
        olast_next  = 1'b0;
        ovalid_next = out_ready ? 1'b0 : ovalid_reg;
        unique case (cmd.emit)
            EMIT_NONE: begin
                owe_next = owe_reg;
                oside_next = oside_reg;
                ooff_next = ooff_reg;
                obyte_next = obyte_reg;
                ost_next = ost_reg;
                olast_next = olast_reg;
            end
            EMIT_START: begin
                obyte_next  = cfg.start_marker;
                fill_next   = fill_reg + 15'd1;
                ovalid_next = 1'b1;
            end
            EMIT_ESC: begin
                obyte_next  = cfg.escape_marker;
                fill_next   = fill_reg + 15'd1;
                ovalid_next = 1'b1;
            end
            EMIT_BYTE: begin
                obyte_next  = cur_byte;
                olast_next  = status.last_byte;
                fill_next   = fill_reg + 15'd1;
                ovalid_next = 1'b1;
            end
            EMIT_XOR: begin
                obyte_next  = cur_byte ^ cfg.escape_mask;
                olast_next  = status.last_byte;
                fill_next   = fill_reg + 15'd1;
                ovalid_next = 1'b1;
            end
            EMIT_SWAP: begin
                side_next   = ~side_reg;
                fill_next   = 15'd0;
                owe_next    = 1'b0;
                oside_next  = ~side_reg;
                ooff_next   = 14'd0;
                olast_next  = 1'b1;
                ovalid_next = 1'b1;
            end
            EMIT_REJECT: begin
                owe_next    = 1'b0;
                ost_next    = 1'b1;
                olast_next  = 1'b1;
                ovalid_next = 1'b1;
            end
            default: ovalid_next = ovalid_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= 15'd0;
            side_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            side_reg   <= side_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        owe_reg   <= owe_next;
        oside_reg <= oside_next;
        ooff_reg  <= ooff_next;
        obyte_reg <= obyte_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

    assign out_valid        = ovalid_reg;
    assign out_write_enable = owe_reg;
    assign out_buffer_side  = oside_reg;
    assign out_write_offset = ooff_reg;
    assign out_byte         = obyte_reg;
    assign out_status       = ost_reg;
    assign out_last         = olast_reg;

endmodule

`default_nettype wire

@@ hdl/escaped_packet_framer.sv @@
// Escaped packet framer top level: stream ports, APB registers.
// Instantiates epf_regs, epf_ctrl and epf_datapath; depends on epf_pkg.
//
// Each slave transaction is one request. An append request frames a packet
// (start byte, timestamp, frame id, then payload bytes, most significant
// first, with start and escape bytes stuffed) into the current buffer half,
// one master transaction per written byte, tagged with its offset; the
// packet is rejected with a single status transaction when (7+n)*2 bytes are
// not free. A swap request flips the buffer half, clears the fill level and
// returns one transaction. One request is in flight at a time: it is accepted
// in the idle state, the space check shares its state with the first output
// transaction, and each further byte follows from the controller feeding the
// single output register, which holds while m_axis_tready is low.
`default_nettype none

module escaped_packet_framer import epf_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [31:0] timestamp, [47:32] frame_id, [111:48] payload,
    // [115:112] payload_bytes, [119:116] zero
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  wire logic                  s_axis_tuser,
    // Framed byte stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] buffer_side, [14:1] write_offset, [22:15] out_byte, [23] zero
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // [0] write_enable, [1] status
    output logic [M_TUSER_W-1:0]       m_axis_tuser,
    output logic                       m_axis_tlast,
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    cfg_t         cfg;
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    logic         o_we;
    logic         o_side;
    logic [13:0]  o_off;
    logic [7:0]   o_byte;
    logic         o_st;

    epf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    epf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    epf_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .in_req_type      (s_axis_tuser),
        .in_timestamp     (s_axis_tdata[31:0]),
        .in_frame_id      (s_axis_tdata[47:32]),
        .in_payload       (s_axis_tdata[111:48]),
        .in_payload_bytes (s_axis_tdata[115:112]),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_write_enable (o_we),
        .out_buffer_side  (o_side),
        .out_write_offset (o_off),
        .out_byte         (o_byte),
        .out_status       (o_st),
        .out_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, o_byte, o_off, o_side};
    assign m_axis_tuser = {o_st, o_we};

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for escaped_packet_framer: requests drive the slave
// stream, framed bytes are checked against a built-in framing predictor.
// Depends on epf_pkg and the escaped_packet_framer RTL.

module tb_top;
    import epf_pkg::*;

    localparam int FRAMER_BUF_BYTES   = 16384;
    localparam int FRAMER_MAX_PAYLOAD = 8;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int REPORT_LIMIT       = 10;

    // One framed byte / status transaction on the master side
    typedef struct packed {
        logic        we;
        logic        side;
        logic [13:0] offset;
        logic [7:0]  data;
        logic        status;
        logic        last;
    } beat_t;

    // One row of the directed table: a register write or a request
    typedef struct packed {
        logic        is_cfg;
        reg_idx_t    idx;
        logic [31:0] value;
        logic        swap;
        logic [31:0] ts;
        logic [15:0] id;
        logic [63:0] pl;
        logic [3:0]  nb;
        logic        typed;
        beat_t       want;
    } step_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [31:0] timestamp, [47:32] frame_id, [111:48] payload,
    // [115:112] payload_bytes, [119:116] zero
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // [0] req_type
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [0] buffer_side, [14:1] write_offset, [22:15] out_byte, [23] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] write_enable, [1] status
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [3:0]           paddr         = '0;
    logic [31:0]          pwdata        = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Predictor copy of registers and framer state
    logic [14:0] cfg_size  = 15'd16384;
    logic [7:0]  cfg_start = 8'd126;
    logic [7:0]  cfg_esc   = 8'd125;
    logic [7:0]  cfg_mask  = 8'd32;
    logic [14:0] fill_lvl  = '0;
    logic        buf_side  = 1'b0;

    beat_t pending_beats[$];
    beat_t obs_beat;
    beat_t exp_beat;
    int    fail_count = 0;
    int    cycle_count = 0;
    logic  stall_en = 1'b1;

    step_t directed_steps [29];
    int    row;
    int    phase;
    int    item;
    int    b;
    logic [31:0] r_ts;
    logic [15:0] r_id;
    logic [63:0] r_pl;
    logic [3:0]  r_nb;

    escaped_packet_framer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        m_axis_tready <= stall_en ? ($urandom_range(0, 99) >= 30) : 1'b1;
    end

    // ---------------- framing predictor ----------------

    function automatic void emit_beat(logic [7:0] val);
        beat_t t;
        t = '{we: 1'b1, side: buf_side, offset: fill_lvl[13:0], data: val,
              status: 1'b0, last: 1'b0};
        pending_beats.push_back(t);
        fill_lvl = fill_lvl + 15'd1;
    endfunction

    // Marker bytes go out as escape + (byte ^ mask)
    function automatic void emit_stuffed(logic [7:0] val);
        if (val == cfg_start || val == cfg_esc) begin
            emit_beat(cfg_esc);
            emit_beat(val ^ cfg_mask);
        end else begin
            emit_beat(val);
        end
    endfunction

    function automatic void frame_request(logic swap, logic [31:0] ts, logic [15:0] id,
                                          logic [63:0] pl, logic [3:0] nb);
        int    n;
        int    usable;
        int    room;
        int    need;
        int    i;
        beat_t t;
        if (swap) begin
            buf_side = ~buf_side;
            fill_lvl = '0;
            t = '{we: 1'b0, side: buf_side, offset: '0, data: '0, status: 1'b0, last: 1'b1};
            pending_beats.push_back(t);
            return;
        end
        n      = (int'(nb) > FRAMER_MAX_PAYLOAD) ? FRAMER_MAX_PAYLOAD : int'(nb);
        usable = (int'(cfg_size) < FRAMER_BUF_BYTES) ? int'(cfg_size) : FRAMER_BUF_BYTES;
        room   = (int'(fill_lvl) < usable) ? usable - int'(fill_lvl) : 0;
        need   = (7 + n) * 2;
        // Worst-case space check, whole packet rejected
        if (need > room) begin
            t = '{we: 1'b0, side: buf_side, offset: fill_lvl[13:0], data: '0,
                  status: 1'b1, last: 1'b1};
            pending_beats.push_back(t);
            return;
        end
        emit_beat(cfg_start);
        for (i = 3; i >= 0; i--) emit_stuffed(ts[8*i +: 8]);
        for (i = 1; i >= 0; i--) emit_stuffed(id[8*i +: 8]);
        for (i = n - 1; i >= 0; i--) emit_stuffed(pl[8*i +: 8]);
        t = pending_beats.pop_back();
        t.last = 1'b1;
        pending_beats.push_back(t);
    endfunction

    // ---------------- directed table rows ----------------

    function automatic step_t pkt_step(logic [31:0] ts, logic [15:0] id,
                                       logic [63:0] pl, logic [3:0] nb);
        step_t s;
        s    = '0;
        s.ts = ts;
        s.id = id;
        s.pl = pl;
        s.nb = nb;
        return s;
    endfunction

    function automatic step_t swap_step(logic side);
        step_t s;
        s       = pkt_step(32'hFFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
        s.swap  = 1'b1;
        s.typed = 1'b1;
        s.want  = '{we: 1'b0, side: side, offset: '0, data: '0, status: 1'b0, last: 1'b1};
        return s;
    endfunction

    function automatic step_t reject_step(logic side, logic [13:0] off, logic [3:0] nb);
        step_t s;
        s       = pkt_step(32'h0BAD_F00D, 16'h1234, 64'h0011_2233_4455_6677, nb);
        s.typed = 1'b1;
        s.want  = '{we: 1'b0, side: side, offset: off, data: '0, status: 1'b1, last: 1'b1};
        return s;
    endfunction

    function automatic step_t cfg_step(reg_idx_t idx, logic [31:0] v);
        step_t s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.value  = v;
        return s;
    endfunction

    // ---------------- random content ----------------

    // Random byte, often one of the current markers so stuffing is exercised
    function automatic logic [7:0] field_byte();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? cfg_start : cfg_esc;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] pick_marker();
        case ($urandom_range(0, 4))
            0: return 32'h00;
            1: return 32'hFF;
            default: return 32'($urandom_range(0, 255));
        endcase
    endfunction

    // ---------------- bus tasks ----------------

    // One request transaction; prediction runs at the accepting edge
    task automatic send_request(logic swap, logic [31:0] ts, logic [15:0] id,
                                logic [63:0] pl, logic [3:0] nb);
        if (stall_en && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 35)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, nb, pl, id, ts};
        s_axis_tuser  <= swap;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        frame_request(swap, ts, id, pl, nb);
    endtask

    // Stop requesting and let every outstanding transaction drain
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup phase, then access phase until pready, then the predictor copy is updated
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BUFFER_SIZE:   cfg_size  = value[14:0];
            REG_START_MARKER:  cfg_start = value[7:0];
            REG_ESCAPE_MARKER: cfg_esc   = value[7:0];
            REG_ESCAPE_MASK:   cfg_mask  = value[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // ---------------- result checker ----------------

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            obs_beat = '{we: m_axis_tuser[0], side: m_axis_tdata[0],
                         offset: m_axis_tdata[14:1], data: m_axis_tdata[22:15],
                         status: m_axis_tuser[1], last: m_axis_tlast};
            if (pending_beats.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected: we=%0d side=%0d off=%0d byte=%h st=%0d last=%0d",
                             obs_beat.we, obs_beat.side, obs_beat.offset, obs_beat.data,
                             obs_beat.status, obs_beat.last);
            end else begin
                exp_beat = pending_beats.pop_front();
                if (obs_beat !== exp_beat) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $write("mismatch: exp we=%0d side=%0d off=%0d byte=%h st=%0d last=%0d",
                               exp_beat.we, exp_beat.side, exp_beat.offset, exp_beat.data,
                               exp_beat.status, exp_beat.last);
                        $display(" | got we=%0d side=%0d off=%0d byte=%h st=%0d last=%0d",
                                 obs_beat.we, obs_beat.side, obs_beat.offset, obs_beat.data,
                                 obs_beat.status, obs_beat.last);
                    end
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    initial begin
        directed_steps = '{
            swap_step(1'b1),
            pkt_step(32'h0000_0000, 16'h0000, 64'h0000_0000_0000_0000, 4'd0),
            pkt_step(32'hFFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8),
            // every byte a marker: longest frame
            pkt_step(32'h7E7D_7E7D, 16'h7D7E, 64'h7E7D_7E7D_7E7D_7E7D, 4'd8),
            // payload count beyond the maximum saturates
            pkt_step(32'h1234_5678, 16'hABCD, 64'h0123_4567_89AB_CDEF, 4'd15),
            pkt_step(32'hA5A5_5A5A, 16'h5AA5, 64'hFEDC_BA98_7654_3210, 4'd9),
            pkt_step(32'h0000_007E, 16'h007D, 64'h0000_0000_007E_7D00, 4'd3),
            // zero-size buffer rejects everything
            cfg_step(REG_BUFFER_SIZE, 32'd0),
            swap_step(1'b0),
            reject_step(1'b0, 14'd0, 4'd8),
            reject_step(1'b0, 14'd0, 4'd0),
            // oversized register clamps to the buffer capacity
            cfg_step(REG_BUFFER_SIZE, 32'd32767),
            pkt_step(32'hC0FF_EE00, 16'h7E00, 64'h8877_6655_4433_2211, 4'd8),
            swap_step(1'b1),
            // exact fit, then no room
            cfg_step(REG_BUFFER_SIZE, 32'd14),
            pkt_step(32'h1122_3344, 16'h5566, 64'h0, 4'd0),
            reject_step(1'b1, 14'd7, 4'd0),
            // fill already past a lowered size
            cfg_step(REG_BUFFER_SIZE, 32'd3),
            reject_step(1'b1, 14'd7, 4'd0),
            cfg_step(REG_BUFFER_SIZE, 32'd16384),
            // start and escape markers equal
            cfg_step(REG_START_MARKER, 32'h00),
            cfg_step(REG_ESCAPE_MARKER, 32'h00),
            cfg_step(REG_ESCAPE_MASK, 32'hFF),
            pkt_step(32'h0000_0000, 16'h00FF, 64'h00FF_00FF_00FF_00FF, 4'd8),
            cfg_step(REG_START_MARKER, 32'hFF),
            cfg_step(REG_ESCAPE_MARKER, 32'h80),
            cfg_step(REG_ESCAPE_MASK, 32'h00),
            pkt_step(32'hFF80_FF80, 16'h80FF, 64'h8080_FFFF_0000_80FF, 4'd8),
            swap_step(1'b0)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (row = 0; row < 29; row++) begin
            if (directed_steps[row].is_cfg) begin
                settle_idle();
                write_reg(directed_steps[row].idx, directed_steps[row].value);
            end else begin
                send_request(directed_steps[row].swap, directed_steps[row].ts,
                             directed_steps[row].id, directed_steps[row].pl,
                             directed_steps[row].nb);
                if (directed_steps[row].typed) begin
                    void'(pending_beats.pop_back());
                    pending_beats.push_back(directed_steps[row].want);
                end
            end
        end

        // Random phases, each with its own register setting
        for (phase = 0; phase < 6; phase++) begin
            settle_idle();
            stall_en <= (phase != 2);
            case (phase)
                0: write_reg(REG_BUFFER_SIZE, 32'd16384);
                1: write_reg(REG_BUFFER_SIZE, 32'($urandom_range(60, 400)));
                2: write_reg(REG_BUFFER_SIZE, 32'd32767);
                3: write_reg(REG_BUFFER_SIZE, 32'($urandom_range(14, 60)));
                4: write_reg(REG_BUFFER_SIZE, 32'($urandom_range(0, 32767)));
                default: write_reg(REG_BUFFER_SIZE, 32'($urandom_range(100, 1000)));
            endcase
            write_reg(REG_START_MARKER, pick_marker());
            write_reg(REG_ESCAPE_MARKER, pick_marker());
            write_reg(REG_ESCAPE_MASK, pick_marker());
            for (item = 0; item < 25; item++) begin
                for (b = 0; b < 4; b++) r_ts[8*b +: 8] = field_byte();
                for (b = 0; b < 2; b++) r_id[8*b +: 8] = field_byte();
                for (b = 0; b < 8; b++) r_pl[8*b +: 8] = field_byte();
                r_nb = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(0, 8));
                send_request($urandom_range(0, 9) == 0, r_ts, r_id, r_pl, r_nb);
            end
        end

        settle_idle();
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
